// ===== src/cartesian_to_spherical_unit_assert.svh =====
// Assertion macros used by the port-level checker of the spherical conversion unit.
// No dependencies; each macro expands to one labelled concurrent assertion.
`ifndef CARTESIAN_TO_SPHERICAL_UNIT_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C2S_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define C2S_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/c2s_pkg.sv =====
// Shared types, widths and elaboration-time constant functions for the
// spherical conversion unit. No dependencies.
package c2s_pkg;

  localparam int ASCALE   = 60;
  localparam int PRESCALE = 24;
  localparam int KF_FRAC  = 30;
  localparam int ACC_W    = 64;
  localparam int RANGE_W  = 20;
  localparam int AZ_W     = 19;
  localparam int EL_W     = 18;

  typedef logic [63:0]        u64_t;
  typedef logic signed [63:0] s64_t;

  typedef struct packed {
    logic last;
    logic degen;
    logic rho_zero;
    logic x_zero;
    logic y_zero;
    logic z_zero;
    logic x_pos;
    logic y_pos;
    logic z_pos;
  } c2s_flags_t;

  // Shift-subtract quotient, used only to build constants.
  function automatic u64_t udiv64(u64_t n, u64_t d);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic u64_t isqrt64(u64_t v);
    u64_t res;
    u64_t rem;
    u64_t bit_w;
    res   = '0;
    rem   = v;
    bit_w = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // atan(1/m) in units of 2^-60 rad by its alternating series
  function automatic s64_t atan_recip(u64_t m);
    u64_t p;
    u64_t mm;
    u64_t term;
    s64_t sum;
    p   = udiv64(64'd1 << ASCALE, m);
    mm  = m * m;
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != 0) begin
        term = udiv64(p, u64_t'(2 * k + 1));
        if ((k & 1) == 0) sum = sum + s64_t'(term);
        else sum = sum - s64_t'(term);
        p = udiv64(p, mm);
      end
    end
    return sum;
  endfunction

  function automatic s64_t atan_entry(int i);
    if (i == 0) return atan_recip(64'd2) + atan_recip(64'd3);
    return atan_recip(64'd1 << i);
  endfunction

  function automatic u64_t cordic_gain(int iters);
    u64_t kf;
    u64_t f;
    u64_t prod;
    kf = 64'd1 << KF_FRAC;
    for (int i = 0; i < 32; i++) begin
      if (i < iters) begin
        f    = isqrt64((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
        prod = kf * f;
        kf   = prod >> KF_FRAC;
      end
    end
    return kf;
  endfunction

  function automatic s64_t to_units_const(s64_t a, int sh);
    s64_t t;
    t = a + s64_t'(64'd1 << (sh - 1));
    return t >>> sh;
  endfunction

endpackage

// ===== src/c2s_sqrt.sv =====
// Pipelined integer square root with round to nearest, one root bit per stage.
// Depends on nothing but its parameters; a tag travels alongside each item.
module c2s_sqrt #(
  parameter int RW    = 20,
  parameter int TAG_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [2*RW-1:0]   sq_i,
  input  logic [TAG_W-1:0]  tag_i,
  output logic              valid_o,
  output logic [RW:0]       root_o,
  output logic [TAG_W-1:0]  tag_o
);
  localparam int REM_W = RW + 2;

  logic [REM_W-1:0]  rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [2*RW-1:0]   sq_q   [RW];
  logic [TAG_W-1:0]  tag_q  [RW+1];
  logic [RW:0]       vld_q;
  logic [RW:0]       res_q;
  logic [REM_W-1:0]  root_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RW-1:0], valid_i};
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int B = RW - 1 - j;
    logic [REM_W-1:0] rem_src;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [RW-1:0]    root_src;
    logic [2*RW-1:0]  sq_src;
    logic [TAG_W-1:0] tag_src;

    if (j == 0) begin : g_first
      assign rem_src  = '0;
      assign root_src = '0;
      assign sq_src   = sq_i;
      assign tag_src  = tag_i;
    end else begin : g_next
      assign rem_src  = rem_q[j-1];
      assign root_src = root_q[j-1];
      assign sq_src   = sq_q[j-1];
      assign tag_src  = tag_q[j-1];
    end

    // bring down the next two radicand bits and try root bit = 1
    assign rem_sh = {rem_src[REM_W-3:0], sq_src[2*B+1 -: 2]};
    assign trial  = {root_src, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_sh >= trial) begin
          rem_q[j]  <= rem_sh - trial;
          root_q[j] <= {root_src[RW-2:0], 1'b1};
        end else begin
          rem_q[j]  <= rem_sh;
          root_q[j] <= {root_src[RW-2:0], 1'b0};
        end
        sq_q[j]  <= sq_src;
        tag_q[j] <= tag_src;
      end
    end
  end

  assign root_ext = REM_W'(root_q[RW-1]);

  // remainder above the root means the value sits past the halfway point
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q      <= (RW+1)'(root_q[RW-1]) + (RW+1)'(rem_q[RW-1] > root_ext);
      tag_q[RW]  <= tag_q[RW-1];
    end
  end

  assign valid_o = vld_q[RW];
  assign root_o  = res_q;
  assign tag_o   = tag_q[RW];

endmodule

// ===== src/c2s_cordic.sv =====
// Pipelined CORDIC vectoring: quadrant fold, then one micro-rotation per stage.
// Uses c2s_pkg for the arctangent constants; a tag travels with each item.
module c2s_cordic #(
  parameter int W     = 48,
  parameter int ITERS = 20,
  parameter int TAG_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [W-1:0]              x_i,
  input  logic signed [W-1:0]              y_i,
  input  logic [TAG_W-1:0]                 tag_i,
  output logic                             valid_o,
  output logic signed [W-1:0]              x_o,
  output logic signed [c2s_pkg::ACC_W-1:0] acc_o,
  output logic [TAG_W-1:0]                 tag_o
);
  import c2s_pkg::*;

  localparam s64_t HALF_PI = s64_t'(atan_entry(0) <<< 1);

  logic signed [W-1:0]     xs_q  [ITERS+1];
  logic signed [W-1:0]     ys_q  [ITERS+1];
  logic signed [ACC_W-1:0] acc_q [ITERS+1];
  logic [TAG_W-1:0]        tag_q [ITERS+1];
  logic [ITERS:0]          vld_q;

  logic signed [W-1:0]     x0_d;
  logic signed [W-1:0]     y0_d;
  logic signed [ACC_W-1:0] a0_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ITERS-1:0], valid_i};
    end
  end

  // fold a left-half vector into the right half by a quarter turn
  always_comb begin
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d = y_i;
        y0_d = -x_i;
        a0_d = HALF_PI;
      end else begin
        x0_d = -y_i;
        y0_d = x_i;
        a0_d = -HALF_PI;
      end
    end else begin
      x0_d = x_i;
      y0_d = y_i;
      a0_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xs_q[0]  <= x0_d;
      ys_q[0]  <= y0_d;
      acc_q[0] <= a0_d;
      tag_q[0] <= tag_i;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam s64_t ANG = atan_entry(i);
    logic signed [W-1:0] dx;
    logic signed [W-1:0] dy;

    assign dx = ys_q[i] >>> i;
    assign dy = xs_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (ys_q[i] >= 0) begin
          xs_q[i+1]  <= xs_q[i] + dx;
          ys_q[i+1]  <= ys_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + ANG;
        end else begin
          xs_q[i+1]  <= xs_q[i] - dx;
          ys_q[i+1]  <= ys_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - ANG;
        end
        tag_q[i+1] <= tag_q[i];
      end
    end
  end

  assign valid_o = vld_q[ITERS];
  assign x_o     = xs_q[ITERS];
  assign acc_o   = acc_q[ITERS];
  assign tag_o   = tag_q[ITERS];

endmodule

// ===== src/cartesian_to_spherical_unit.sv =====
// Cartesian to spherical conversion of lidar points, fixed-point pipeline.
// Depends on c2s_pkg, c2s_sqrt and c2s_cordic.
//
// Input channel: in_valid_i with x_mm_i, y_mm_i, z_mm_i (signed mm) and
// last_point_i; the item is taken on a clock edge where in_valid_i is high
// and in_stall_o is low. Output channel: out_valid_o with range_mm_o,
// azimuth_o, elevation_o (2^-ANGLE_FRAC_BITS rad), degenerate_o and
// last_out_o; the item leaves on an edge where out_stall_i is low.
// One item enters per cycle unless in_stall_o is high, and results leave in input order.
// The pipeline holds three front stages, the square root at one bit per stage
// plus a rounding stage, two CORDIC passes of a quadrant fold and one
// micro-rotation per stage, the gain multiply, elevation rounding and the output register.
// The origin gives zero range and angles with degenerate_o set.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is then empty and ready.
module cartesian_to_spherical_unit #(
  parameter int COORD_BITS      = 20,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [COORD_BITS-1:0]       x_mm_i,
  input  logic signed [COORD_BITS-1:0]       y_mm_i,
  input  logic signed [COORD_BITS-1:0]       z_mm_i,
  input  logic                               last_point_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [c2s_pkg::RANGE_W-1:0]        range_mm_o,
  output logic signed [c2s_pkg::AZ_W-1:0]    azimuth_o,
  output logic [c2s_pkg::EL_W-1:0]           elevation_o,
  output logic                               degenerate_o,
  output logic                               last_out_o
);
  import c2s_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int SQ_W  = 2 * CB;
  localparam int RT_W  = CB + 1;
  localparam int W     = CB + 28;
  localparam int ITERS = ANGLE_FRAC_BITS + 4;
  localparam int AQ_W  = ANGLE_FRAC_BITS + 4;
  localparam int KZ_W  = CB + 32;
  localparam int SHIFT = ASCALE - ANGLE_FRAC_BITS;
  localparam int KZ_SH = KF_FRAC - PRESCALE;

  localparam s64_t ROUND_BIAS = s64_t'(64'd1 << (SHIFT - 1));
  localparam s64_t PI60       = s64_t'(atan_entry(0) <<< 2);
  localparam logic signed [AQ_W-1:0] PI_Q  = AQ_W'(to_units_const(PI60, SHIFT));
  localparam logic signed [AQ_W-1:0] HPI_Q = AQ_W'(to_units_const(PI60 >>> 1, SHIFT));
  localparam u64_t KF = cordic_gain(ITERS);
  localparam logic signed [31:0] KF_S = $signed(KF[31:0]);

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    c2s_flags_t           flg;
  } pt_t;

  typedef struct packed {
    logic [RT_W-1:0]      root;
    logic signed [CB-1:0] z;
    c2s_flags_t           flg;
  } az_tag_t;

  typedef struct packed {
    logic [RT_W-1:0]        root;
    logic signed [AQ_W-1:0] azq;
    c2s_flags_t             flg;
  } el_tag_t;

  logic en;

  // front stages
  c2s_flags_t        flg_d;
  pt_t               f_pt_q;
  pt_t               q_pt_q;
  pt_t               s_pt_q;
  logic [SQ_W-1:0]   sqx_d, sqy_d, sqz_d;
  logic [SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [SQ_W-1:0]   sum_q;
  logic              f_vld_q, q_vld_q, s_vld_q;

  // square root
  logic              sq_vld;
  logic [RT_W-1:0]   sq_root;
  pt_t               sq_pt;

  // azimuth pass
  logic signed [CB-1:0]    px_c, py_c;
  logic signed [W-1:0]     az_x_in, az_y_in;
  az_tag_t                 az_tag_in, az_tag;
  logic                    az_vld;
  logic signed [W-1:0]     az_x1;
  logic signed [ACC_W-1:0] az_acc;

  // gain multiply and azimuth rounding
  logic signed [CB-1:0]    kz_z;
  logic signed [KZ_W-1:0]  kz_d, kz_q;
  logic signed [ACC_W-1:0] az_rnd;
  el_tag_t                 k_tag_q;
  logic signed [W-1:0]     x1_q;
  logic                    k_vld_q;

  // elevation pass
  logic signed [W-1:0]     el_x_in;
  logic                    el_vld;
  logic signed [ACC_W-1:0] el_acc;
  el_tag_t                 el_tag;

  // elevation rounding
  logic signed [ACC_W-1:0] el_rnd;
  logic signed [AQ_W-1:0]  elq_q;
  el_tag_t                 r_tag_q;
  logic                    r_vld_q;

  // output register
  logic signed [AQ_W-1:0]  az_sel, el_sel;
  logic                    out_vld_q;
  logic [RANGE_W-1:0]      range_q;
  logic signed [AZ_W-1:0]  az_q;
  logic [EL_W-1:0]         el_q;
  logic                    degen_q, last_q;

  // freeze every stage while a result waits at the output
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    flg_d.last     = last_point_i;
    flg_d.x_zero   = (x_mm_i == '0);
    flg_d.y_zero   = (y_mm_i == '0);
    flg_d.z_zero   = (z_mm_i == '0);
    flg_d.x_pos    = !x_mm_i[CB-1] && (x_mm_i != '0);
    flg_d.y_pos    = !y_mm_i[CB-1] && (y_mm_i != '0);
    flg_d.z_pos    = !z_mm_i[CB-1] && (z_mm_i != '0);
    flg_d.rho_zero = (x_mm_i == '0) && (y_mm_i == '0);
    flg_d.degen    = (x_mm_i == '0) && (y_mm_i == '0) && (z_mm_i == '0);
  end

  assign sqx_d = f_pt_q.x * f_pt_q.x;
  assign sqy_d = f_pt_q.y * f_pt_q.y;
  assign sqz_d = f_pt_q.z * f_pt_q.z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q   <= 1'b0;
      q_vld_q   <= 1'b0;
      s_vld_q   <= 1'b0;
      k_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      f_vld_q   <= in_valid_i;
      q_vld_q   <= f_vld_q;
      s_vld_q   <= q_vld_q;
      k_vld_q   <= az_vld;
      r_vld_q   <= el_vld;
      out_vld_q <= r_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_pt_q <= '{x: x_mm_i, y: y_mm_i, z: z_mm_i, flg: flg_d};
      sqx_q  <= sqx_d;
      sqy_q  <= sqy_d;
      sqz_q  <= sqz_d;
      q_pt_q <= f_pt_q;
      sum_q  <= sqx_q + sqy_q + sqz_q;
      s_pt_q <= q_pt_q;
    end
  end

  c2s_sqrt #(
    .RW    (CB),
    .TAG_W ($bits(pt_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_vld_q),
    .sq_i    (sum_q),
    .tag_i   (s_pt_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .tag_o   (sq_pt)
  );

  assign px_c      = sq_pt.x;
  assign py_c      = sq_pt.y;
  assign az_x_in   = W'(px_c) <<< PRESCALE;
  assign az_y_in   = W'(py_c) <<< PRESCALE;
  assign az_tag_in = '{root: sq_root, z: sq_pt.z, flg: sq_pt.flg};

  c2s_cordic #(
    .W     (W),
    .ITERS (ITERS),
    .TAG_W ($bits(az_tag_t))
  ) u_cordic_az (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_vld),
    .x_i     (az_x_in),
    .y_i     (az_y_in),
    .tag_i   (az_tag_in),
    .valid_o (az_vld),
    .x_o     (az_x1),
    .acc_o   (az_acc),
    .tag_o   (az_tag)
  );

  assign kz_z   = az_tag.z;
  assign kz_d   = kz_z * KF_S;
  assign az_rnd = (az_acc + ROUND_BIAS) >>> SHIFT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kz_q    <= kz_d;
      x1_q    <= az_x1;
      k_tag_q <= '{root: az_tag.root, azq: AQ_W'(az_rnd), flg: az_tag.flg};
    end
  end

  // z scaled by the CORDIC gain, back at the prescaled coordinate scale
  assign el_x_in = W'(kz_q >>> KZ_SH);

  c2s_cordic #(
    .W     (W),
    .ITERS (ITERS),
    .TAG_W ($bits(el_tag_t))
  ) u_cordic_el (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (k_vld_q),
    .x_i     (el_x_in),
    .y_i     (x1_q),
    .tag_i   (k_tag_q),
    .valid_o (el_vld),
    .x_o     (),
    .acc_o   (el_acc),
    .tag_o   (el_tag)
  );

  assign el_rnd = (el_acc + ROUND_BIAS) >>> SHIFT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      elq_q   <= AQ_W'(el_rnd);
      r_tag_q <= el_tag;
    end
  end

  // axis and origin cases override the CORDIC angles, which are otherwise clamped
  always_comb begin
    priority if (r_tag_q.flg.rho_zero) begin
      az_sel = '0;
    end else if (r_tag_q.flg.y_zero) begin
      az_sel = r_tag_q.flg.x_pos ? '0 : PI_Q;
    end else if (r_tag_q.flg.x_zero) begin
      az_sel = r_tag_q.flg.y_pos ? HPI_Q : -HPI_Q;
    end else if (r_tag_q.azq < -PI_Q) begin
      az_sel = -PI_Q;
    end else if (r_tag_q.azq > PI_Q) begin
      az_sel = PI_Q;
    end else begin
      az_sel = r_tag_q.azq;
    end

    priority if (r_tag_q.flg.degen) begin
      el_sel = '0;
    end else if (r_tag_q.flg.rho_zero) begin
      el_sel = r_tag_q.flg.z_pos ? '0 : PI_Q;
    end else if (r_tag_q.flg.z_zero) begin
      el_sel = HPI_Q;
    end else if (elq_q < 0) begin
      el_sel = '0;
    end else if (elq_q > PI_Q) begin
      el_sel = PI_Q;
    end else begin
      el_sel = elq_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      range_q <= RANGE_W'(r_tag_q.root);
      az_q    <= AZ_W'(az_sel);
      el_q    <= EL_W'(el_sel);
      degen_q <= r_tag_q.flg.degen;
      last_q  <= r_tag_q.flg.last;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign range_mm_o   = range_q;
  assign azimuth_o    = az_q;
  assign elevation_o  = el_q;
  assign degenerate_o = degen_q;
  assign last_out_o   = last_q;

endmodule

// ===== src/c2s_checker.sv =====
// Port-level checks for the spherical conversion unit, bound to the top level.
// Depends on cartesian_to_spherical_unit_assert.svh and c2s_pkg.
`include "cartesian_to_spherical_unit_assert.svh"

module c2s_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [c2s_pkg::RANGE_W-1:0]     range_mm_o,
  input logic signed [c2s_pkg::AZ_W-1:0] azimuth_o,
  input logic [c2s_pkg::EL_W-1:0]        elevation_o,
  input logic                            degenerate_o
);

  `C2S_ASSERT_IMP(a_stall_only_on_held_out, clk_i, rst_ni, in_stall_o,
                  out_valid_o && out_stall_i, "input stalled without a held result")

  `C2S_ASSERT_IMP(a_origin_all_zero, clk_i, rst_ni, out_valid_o && degenerate_o,
                  range_mm_o == '0 && azimuth_o == '0 && elevation_o == '0,
                  "origin item has nonzero fields")

  `C2S_ASSERT_NXT(a_out_valid_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
                  out_valid_o, "stalled result dropped")

  `C2S_ASSERT_NXT(a_out_payload_holds, clk_i, rst_ni, out_valid_o && out_stall_i,
                  $stable(range_mm_o) && $stable(azimuth_o) && $stable(elevation_o),
                  "stalled result changed")

endmodule

bind cartesian_to_spherical_unit c2s_checker u_c2s_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .range_mm_o   (range_mm_o),
  .azimuth_o    (azimuth_o),
  .elevation_o  (elevation_o),
  .degenerate_o (degenerate_o)
);

// ===== test/cartesian_to_spherical_unit_checker.sv =====
// Checker for the spherical conversion unit: watches both channels, predicts
// range and angles in fixed point and compares each result item in order.
// Depends on c2s_pkg for widths and 64-bit types.
module cartesian_to_spherical_unit_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic signed [19:0]              x_mm_i,
  input  logic signed [19:0]              y_mm_i,
  input  logic signed [19:0]              z_mm_i,
  input  logic                            last_point_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [c2s_pkg::RANGE_W-1:0]     range_mm_i,
  input  logic signed [c2s_pkg::AZ_W-1:0] azimuth_i,
  input  logic [c2s_pkg::EL_W-1:0]        elevation_i,
  input  logic                            degenerate_i,
  input  logic                            last_out_i,
  output int                              errors_o,
  output int                              outstanding_o
);
  import c2s_pkg::*;

  localparam int FRAC  = 16;
  localparam int ITERS = FRAC + 4;

  typedef struct packed {
    logic [RANGE_W-1:0]     range_mm;
    logic signed [AZ_W-1:0] azimuth;
    logic [EL_W-1:0]        elevation;
    logic                   degenerate;
    logic                   last;
  } polar_t;

  polar_t polar_q[$];
  s64_t   rot_angle[ITERS];
  s64_t   pi_fine;
  s64_t   pi_units;
  s64_t   half_pi_units;
  u64_t   gain;

  function automatic u64_t int_sqrt(u64_t v);
    u64_t root;
    u64_t b;
    root = 0;
    b    = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= root + b) begin
        v    = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // arctangent of 1/m in 2^-60 rad, series truncated term by term
  function automatic s64_t arctan_inv(u64_t m);
    u64_t p;
    s64_t acc;
    int   k;
    p   = (64'd1 << ASCALE) / m;
    acc = 0;
    k   = 0;
    while (p != 0) begin
      if (k % 2 == 0) acc = acc + s64_t'(p / u64_t'(2 * k + 1));
      else acc = acc - s64_t'(p / u64_t'(2 * k + 1));
      p = p / (m * m);
      k++;
    end
    return acc;
  endfunction

  function automatic s64_t quantize(s64_t a, s64_t lo, s64_t hi);
    s64_t q;
    q = (a + (s64_t'(1) <<< (ASCALE - 1 - FRAC))) >>> (ASCALE - FRAC);
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic s64_t rotate_to_axis(s64_t xv, s64_t yv, output s64_t x_end);
    s64_t acc;
    s64_t t;
    s64_t dx;
    s64_t dy;
    acc = 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv = yv; yv = -t; acc = pi_fine / 2;
      end else begin
        xv = -yv; yv = t; acc = -(pi_fine / 2);
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv >= 0) begin
        xv = xv + dx; yv = yv - dy; acc = acc + rot_angle[i];
      end else begin
        xv = xv - dx; yv = yv + dy; acc = acc - rot_angle[i];
      end
    end
    x_end = xv;
    return acc;
  endfunction

  function automatic polar_t convert(s64_t x, s64_t y, s64_t z, logic last);
    polar_t res;
    u64_t   rho2;
    u64_t   sum2;
    u64_t   r;
    s64_t   az;
    s64_t   el;
    s64_t   x1;
    s64_t   unused;
    res      = '0;
    res.last = last;
    rho2     = u64_t'(x * x) + u64_t'(y * y);
    sum2     = rho2 + u64_t'(z * z);
    if (sum2 == 0) begin
      res.degenerate = 1'b1;
      return res;
    end
    r = int_sqrt(sum2);
    if (sum2 - r * r > r) r++;
    x1 = 0;
    az = 0;
    if (rho2 != 0) az = rotate_to_axis(x <<< PRESCALE, y <<< PRESCALE, x1);
    if (rho2 == 0) az = 0;
    else if (y == 0) az = (x > 0) ? 0 : pi_units;
    else if (x == 0) az = (y > 0) ? half_pi_units : -half_pi_units;
    else az = quantize(az, -pi_units, pi_units);
    if (rho2 == 0) el = (z > 0) ? 0 : pi_units;
    else if (z == 0) el = half_pi_units;
    else el = quantize(rotate_to_axis((z * s64_t'(gain)) >>> (KF_FRAC - PRESCALE), x1,
                                      unused), 0, pi_units);
    res.range_mm  = r[RANGE_W-1:0];
    res.azimuth   = az[AZ_W-1:0];
    res.elevation = el[EL_W-1:0];
    return res;
  endfunction

  initial begin
    u64_t f;
    rot_angle[0] = arctan_inv(2) + arctan_inv(3);
    for (int i = 1; i < ITERS; i++) rot_angle[i] = arctan_inv(64'd1 << i);
    pi_fine = 4 * rot_angle[0];
    gain    = 64'd1 << KF_FRAC;
    for (int i = 0; i < ITERS; i++) begin
      f    = int_sqrt((64'd1 << 60) + (64'd1 << (60 - 2 * i)));
      gain = (gain * f) >> KF_FRAC;
    end
    pi_units      = quantize(pi_fine, 0, 64'sh7fff_ffff_ffff_ffff);
    half_pi_units = quantize(pi_fine / 2, 0, 64'sh7fff_ffff_ffff_ffff);
    errors_o      = 0;
    outstanding_o = 0;
  end

  always @(posedge clk_i) begin
    polar_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        polar_q.push_back(convert(x_mm_i, y_mm_i, z_mm_i, last_point_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (polar_q.size() == 0) begin
          $display("%0t: result item with nothing expected", $time);
          errors_o++;
        end else begin
          want = polar_q.pop_front();
          if (want.range_mm !== range_mm_i) begin
            $display("%0t: range_mm expected %0d got %0d", $time, want.range_mm, range_mm_i);
            errors_o++;
          end
          if (want.azimuth !== azimuth_i) begin
            $display("%0t: azimuth expected %0d got %0d", $time, want.azimuth, azimuth_i);
            errors_o++;
          end
          if (want.elevation !== elevation_i) begin
            $display("%0t: elevation expected %0d got %0d", $time, want.elevation,
                     elevation_i);
            errors_o++;
          end
          if (want.degenerate !== degenerate_i) begin
            $display("%0t: degenerate expected %0b got %0b", $time, want.degenerate,
                     degenerate_i);
            errors_o++;
          end
          if (want.last !== last_out_i) begin
            $display("%0t: last_out expected %0b got %0b", $time, want.last, last_out_i);
            errors_o++;
          end
        end
      end
      outstanding_o = polar_q.size();
    end
  end

endmodule

// ===== test/cartesian_to_spherical_unit_test.sv =====
// Testbench top for the spherical conversion unit: clock, reset, point
// stimulus, receiver stalls, watchdog and verdict. Depends on c2s_pkg, the
// unit itself and cartesian_to_spherical_unit_checker.
module cartesian_to_spherical_unit_test;
  import c2s_pkg::*;

  localparam int N_RANDOM  = 1080;
  localparam int CALM_TAIL = 150;
  localparam int WD_LIMIT  = 3000;
  localparam int MAXC      = 524287;
  localparam int MINC      = -524288;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [19:0] x_mm_i = '0;
  logic signed [19:0] y_mm_i = '0;
  logic signed [19:0] z_mm_i = '0;
  logic last_point_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  logic [RANGE_W-1:0] range_mm_o;
  logic signed [AZ_W-1:0] azimuth_o;
  logic [EL_W-1:0] elevation_o;
  logic degenerate_o;
  logic last_out_o;
  int errors;
  int outstanding;
  int points_sent = 0;
  bit calm = 1'b0;
  int idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  cartesian_to_spherical_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .x_mm_i, .y_mm_i, .z_mm_i,
    .last_point_i, .out_valid_o, .out_stall_i, .range_mm_o, .azimuth_o,
    .elevation_o, .degenerate_o, .last_out_o
  );

  cartesian_to_spherical_unit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .x_mm_i, .y_mm_i,
    .z_mm_i, .last_point_i, .out_valid_i(out_valid_o), .out_stall_i,
    .range_mm_i(range_mm_o), .azimuth_i(azimuth_o), .elevation_i(elevation_o),
    .degenerate_i(degenerate_o), .last_out_i(last_out_o), .errors_o(errors),
    .outstanding_o(outstanding)
  );

  task automatic send_point(int x, int y, int z, bit last);
    in_valid_i   <= 1'b1;
    x_mm_i       <= x[19:0];
    y_mm_i       <= y[19:0];
    z_mm_i       <= z[19:0];
    last_point_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    points_sent++;
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  function automatic int pick_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $urandom_range(0, 1) ? MAXC : MINC;
      2: return $signed($urandom_range(0, 40)) - 20;
      3: return $signed($urandom_range(0, 8000)) - 4000;
      default: return $signed(20'($urandom()));
    endcase
  endfunction

  // directed points: origin, axes both ways, extremes, xy plane
  initial begin
    int pts[$][3];
    pts = '{'{0, 0, 0}, '{0, 0, 5}, '{0, 0, -5}, '{7, 0, 0}, '{-7, 0, 0},
            '{0, 9, 0}, '{0, -9, 0}, '{0, 0, MAXC}, '{0, 0, MINC},
            '{MAXC, MAXC, MAXC}, '{MINC, MINC, MINC}, '{MAXC, MINC, MAXC},
            '{MINC, MAXC, MINC}, '{MINC, 0, 3}, '{0, MINC, -3}, '{3, 4, 0},
            '{-3, -4, 0}, '{1, 1, 1}, '{-1, 1, -1}, '{-1, -1, 1}, '{MINC, -1, 0},
            '{MINC, 1, 0}, '{1, -1, MAXC}};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (pts[i]) begin
      send_point(pts[i][0], pts[i][1], pts[i][2], i % 3 == 0);
      maybe_gap();
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM - CALM_TAIL) calm = 1'b1;
      // drain completely once mid-run
      if (n == 700) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (outstanding != 0) @(posedge clk_i);
      end
      send_point(pick_coord(), pick_coord(), pick_coord(), $urandom_range(0, 1));
      maybe_gap();
    end
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random stall bursts and one long hold to back up the pipeline
  initial begin
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && points_sent >= 300) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/c2s_pkg.sv
src/c2s_sqrt.sv
src/c2s_cordic.sv
src/cartesian_to_spherical_unit.sv
src/c2s_checker.sv
test/cartesian_to_spherical_unit_checker.sv
test/cartesian_to_spherical_unit_test.sv
